// File: src/ptd_pkg.sv
package ptd_pkg;

  localparam int ADDR_W    = 19;  // offset*4 + slot*4 + 3 fits
  localparam int ENTRIES_W = 13;
  localparam int OFFSET_W  = 16;
  localparam int WORD_W    = 16;
  localparam int COLOR_W   = 15;
  localparam int ENTRY_W   = 12;
  localparam int SLOT_W    = 14;
  localparam int TEXEL_W   = 32;

  typedef enum logic [2:0] {
    FMT_A3I5   = 3'd0,
    FMT_PAL4   = 3'd1,
    FMT_PAL16  = 3'd2,
    FMT_PAL256 = 3'd3,
    FMT_COMP   = 3'd4,
    FMT_A5I3   = 3'd5,
    FMT_DIRECT = 3'd6
  } fmt_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_FORMAT  = 2'd0,
    CFG_T0      = 2'd1,
    CFG_OFFSET  = 2'd2,
    CFG_ENTRIES = 2'd3
  } cfg_idx_t;

  // compressed block interpolation modes
  typedef enum logic [1:0] {
    CMP_READ3 = 2'd0,
    CMP_AVG   = 2'd1,
    CMP_READ4 = 2'd2,
    CMP_BLEND = 2'd3
  } cmp_mode_t;

  // one issue step, handed to the texel stage alongside the RAM read
  typedef struct packed {
    logic        ld;    // a palette slot is filled this step
    logic        fin;   // last step of a decode: block is complete
    logic [1:0]  slot;
    logic        miss;  // entry out of range, RAM not read
    fmt_t        fmt;
    logic        t0;
    cmp_mode_t   mode;
    logic [WORD_W-1:0] word;
  } step_t;

endpackage

// File: src/ptd_palette_ram.sv
module ptd_palette_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [AW-1:0]           addr,
  input  logic [ptd_pkg::COLOR_W-1:0] wdata,
  output logic [ptd_pkg::COLOR_W-1:0] rdata
);
  import ptd_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/ptd_issue.sv
module ptd_issue #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptd_pkg::op_t                  in_op,
  input  logic [ptd_pkg::ENTRY_W-1:0]   in_addr,
  input  logic [ptd_pkg::WORD_W-1:0]    in_word,
  input  logic [ptd_pkg::WORD_W-1:0]    in_slot,
  input  ptd_pkg::fmt_t                 fmt,
  input  logic                          t0,
  input  logic [ptd_pkg::OFFSET_W-1:0]  offset,
  input  logic [ptd_pkg::ENTRIES_W-1:0] entries,
  input  logic                          fin_ok,
  output ptd_pkg::step_t                step,
  output logic                          mem_en,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_addr,
  output logic [ptd_pkg::COLOR_W-1:0]   mem_wdata
);
  import ptd_pkg::*;

  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(DEPTH);

  logic                valid_r;
  op_t                 op_r;
  logic [ENTRY_W-1:0]  addr_r;
  logic [WORD_W-1:0]   word_r;
  cmp_mode_t           mode_r;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [1:0]          step_r;

  logic [1:0]          last_step;
  logic                rd_need, fin_cand;
  logic [7:0]          byte_v, idx, sh2, sh4;
  logic [ADDR_W-1:0]   eff_addr, wr_full;
  logic                miss, is_last, go, done, wr_ok;

  assign byte_v = word_r[7:0];
  assign sh2    = byte_v >> {step_r, 1'b0};
  assign sh4    = byte_v >> {step_r[0], 2'b00};

  always_comb begin
    last_step = 2'd0;
    rd_need   = 1'b1;
    fin_cand  = 1'b1;
    idx       = 8'd0;
    case (fmt)
      FMT_A3I5:   idx = {3'b000, byte_v[4:0]};
      FMT_PAL4: begin
        idx       = {6'b0, sh2[1:0]};
        last_step = 2'd3;
      end
      FMT_PAL16: begin
        idx       = {4'b0, sh4[3:0]};
        last_step = 2'd1;
      end
      FMT_PAL256: idx = byte_v;
      FMT_COMP: begin
        idx = {6'b0, step_r};
        case (mode_r)
          CMP_READ3: last_step = 2'd2;
          CMP_READ4: last_step = 2'd3;
          default:   last_step = 2'd1;  // c2 is computed; c3 is blended or transparent
        endcase
      end
      FMT_A5I3:   idx = {5'b0, byte_v[2:0]};
      FMT_DIRECT: rd_need = 1'b0;
      default: begin
        rd_need  = 1'b0;
        fin_cand = 1'b0;
      end
    endcase
  end

  assign base_nxt = ADDR_W'({offset, 2'b00}) +
                    ((fmt == FMT_COMP) ? ADDR_W'({in_slot[SLOT_W-1:0], 2'b00})
                                       : ADDR_W'(0));
  assign eff_addr = base_r + ADDR_W'(idx);
  assign miss     = (eff_addr >= ADDR_W'(entries)) || (eff_addr >= DEPTH_A);

  assign is_last  = (step_r == last_step);
  assign go       = valid_r && (op_r == OP_DECODE) && (!(is_last && fin_cand) || fin_ok);
  assign done     = valid_r && ((op_r == OP_WRITE) || (go && is_last));
  assign in_ready = !valid_r || done;

  assign wr_full  = ADDR_W'(addr_r);
  assign wr_ok    = valid_r && (op_r == OP_WRITE) && (wr_full < DEPTH_A);

  always_comb begin
    step.ld   = go && rd_need;
    step.fin  = go && is_last && fin_cand;
    step.slot = step_r;
    step.miss = miss;
    step.fmt  = fmt;
    step.t0   = t0;
    step.mode = mode_r;
    step.word = word_r;
  end

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = eff_addr[AW-1:0];
    mem_wdata = word_r[COLOR_W-1:0];
    if (wr_ok) begin
      mem_en   = 1'b1;
      mem_we   = 1'b1;
      mem_addr = wr_full[AW-1:0];
    end else if (step.ld && !miss) begin
      mem_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
      step_r  <= 2'd0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (go) begin
      step_r <= step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      addr_r <= in_addr;
      word_r <= in_word;
      mode_r <= cmp_mode_t'(in_slot[15:14]);
      base_r <= base_nxt;
    end
  end

endmodule

// File: src/ptd_texel_out.sv
module ptd_texel_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptd_pkg::step_t              step,
  input  logic [ptd_pkg::COLOR_W-1:0] rd_data,
  output logic                        fin_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptd_pkg::TEXEL_W-1:0] out_data,
  output logic                        out_last
);
  import ptd_pkg::*;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] blend53(input logic [7:0] a, input logic [7:0] b);
    logic [10:0] s;
    s = 11'({a, 2'b00}) + 11'(a) + 11'({b, 1'b0}) + 11'(b);
    return s[10:3];
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  step_t              tag_r;
  logic [COLOR_W-1:0] col_r [4];
  logic [3:0]         miss_r;
  logic [COLOR_W-1:0] col_fwd [4];
  logic [3:0]         miss_fwd;

  logic               blk_valid_r, blk_valid_nxt;
  logic [1:0]         blk_k_r, blk_k_nxt, blk_last_r, blk_last_nxt;
  logic [COLOR_W-1:0] blk_col_r [4];
  logic [3:0]         blk_miss_r;
  fmt_t               blk_fmt_r;
  logic               blk_t0_r;
  cmp_mode_t          blk_mode_r;
  logic [WORD_W-1:0]  blk_word_r;

  logic               out_valid_r;
  logic [TEXEL_W-1:0] out_data_r;
  logic               out_last_r;

  logic               take, pop, pop_last;
  logic [7:0]         byte_v, sh2, sh4;
  logic [1:0]         idx2;
  logic [3:0]         idx4;
  logic [7:0]         ex_rgb  [4][3];
  logic [7:0]         sub_rgb [4][3];
  logic [7:0]         sub_a   [4];
  logic [7:0]         p_rgb   [3];
  logic               p_miss;
  logic [7:0]         t_r, t_g, t_b, t_a;

  // slot fill with bypass of the read returning this cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (tag_r.ld && (tag_r.slot == 2'(k))) begin
        col_fwd[k]  = rd_data;
        miss_fwd[k] = tag_r.miss;
      end else begin
        col_fwd[k]  = col_r[k];
        miss_fwd[k] = miss_r[k];
      end
    end
  end

  assign take     = !out_valid_r || out_ready;
  assign pop      = blk_valid_r && take;
  assign pop_last = pop && (blk_k_r == blk_last_r);
  // issue may send a final step only if the block buffer is free on arrival
  assign fin_ok   = !tag_r.fin && (!blk_valid_r || pop_last);

  always_comb begin
    case (tag_r.fmt)
      FMT_PAL16:          blk_last_nxt = 2'd1;
      FMT_PAL4, FMT_COMP: blk_last_nxt = 2'd3;
      default:            blk_last_nxt = 2'd0;
    endcase
  end

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    blk_k_nxt     = blk_k_r;
    if (tag_r.fin) begin
      blk_valid_nxt = 1'b1;
      blk_k_nxt     = 2'd0;
    end else if (pop) begin
      if (pop_last) begin
        blk_valid_nxt = 1'b0;
      end else begin
        blk_k_nxt = blk_k_r + 2'd1;
      end
    end
  end

  // texel build
  assign byte_v = blk_word_r[7:0];
  assign sh2    = byte_v >> {blk_k_r, 1'b0};
  assign sh4    = byte_v >> {blk_k_r[0], 2'b00};
  assign idx2   = sh2[1:0];
  assign idx4   = sh4[3:0];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ex_rgb[j][0] = blk_miss_r[j] ? 8'd0 : widen5(blk_col_r[j][4:0]);
      ex_rgb[j][1] = blk_miss_r[j] ? 8'd0 : widen5(blk_col_r[j][9:5]);
      ex_rgb[j][2] = blk_miss_r[j] ? 8'd0 : widen5(blk_col_r[j][14:10]);
    end
    for (int c = 0; c < 3; c++) begin
      sub_rgb[0][c] = ex_rgb[0][c];
      sub_rgb[1][c] = ex_rgb[1][c];
      case (blk_mode_r)
        CMP_AVG: begin
          sub_rgb[2][c] = avg2(ex_rgb[0][c], ex_rgb[1][c]);
          sub_rgb[3][c] = 8'd0;
        end
        CMP_READ4: begin
          sub_rgb[2][c] = ex_rgb[2][c];
          sub_rgb[3][c] = ex_rgb[3][c];
        end
        CMP_BLEND: begin
          sub_rgb[2][c] = blend53(ex_rgb[0][c], ex_rgb[1][c]);
          sub_rgb[3][c] = blend53(ex_rgb[1][c], ex_rgb[0][c]);
        end
        default: begin
          sub_rgb[2][c] = ex_rgb[2][c];
          sub_rgb[3][c] = 8'd0;
        end
      endcase
    end
    sub_a[0] = 8'hFF;
    sub_a[1] = 8'hFF;
    sub_a[2] = 8'hFF;
    // color 3 is transparent black unless read or blended
    sub_a[3] = ((blk_mode_r == CMP_READ4) || (blk_mode_r == CMP_BLEND)) ? 8'hFF : 8'd0;
    for (int c = 0; c < 3; c++) begin
      p_rgb[c] = ex_rgb[blk_k_r][c];
    end
    p_miss = blk_miss_r[blk_k_r];
  end

  always_comb begin
    t_r = p_rgb[0];
    t_g = p_rgb[1];
    t_b = p_rgb[2];
    t_a = 8'd0;
    case (blk_fmt_r)
      FMT_A3I5:   t_a = {byte_v[7:5], byte_v[7:5], byte_v[7:6]};
      FMT_A5I3:   t_a = {byte_v[7:3], byte_v[7:5]};
      FMT_PAL4:   t_a = (p_miss || (blk_t0_r && (idx2 == 2'd0))) ? 8'd0 : 8'hFF;
      FMT_PAL16:  t_a = (p_miss || (blk_t0_r && (idx4 == 4'd0))) ? 8'd0 : 8'hFF;
      FMT_PAL256: t_a = (p_miss || (blk_t0_r && (byte_v == 8'd0))) ? 8'd0 : 8'hFF;
      FMT_COMP: begin
        t_r = sub_rgb[idx2][0];
        t_g = sub_rgb[idx2][1];
        t_b = sub_rgb[idx2][2];
        t_a = sub_a[idx2];
      end
      FMT_DIRECT: begin
        t_r = widen5(blk_word_r[4:0]);
        t_g = widen5(blk_word_r[9:5]);
        t_b = widen5(blk_word_r[14:10]);
        t_a = blk_word_r[15] ? 8'hFF : 8'd0;
      end
      default: begin
        t_r = 8'd0;
        t_g = 8'd0;
        t_b = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      blk_valid_r <= 1'b0;
      blk_k_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      tag_r       <= step;
      blk_valid_r <= blk_valid_nxt;
      blk_k_r     <= blk_k_nxt;
      if (take) begin
        out_valid_r <= blk_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.ld) begin
      col_r[tag_r.slot]  <= rd_data;
      miss_r[tag_r.slot] <= tag_r.miss;
    end
    if (tag_r.fin) begin
      for (int k = 0; k < 4; k++) begin
        blk_col_r[k] <= col_fwd[k];
      end
      blk_miss_r <= miss_fwd;
      blk_fmt_r  <= tag_r.fmt;
      blk_t0_r   <= tag_r.t0;
      blk_mode_r <= tag_r.mode;
      blk_word_r <= tag_r.word;
      blk_last_r <= blk_last_nxt;
    end
    if (pop) begin
      out_data_r <= {t_a, t_b, t_g, t_r};
      out_last_r <= (blk_k_r == blk_last_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

// File: src/paletted_texel_decoder.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  tdata: entry_address, data_word, slot_info;
//                                     tuser: opcode
// out_      out  out_tvalid/out_tready tdata: red, green, blue, alpha; tlast: last
// cfg_      in   cfg_we               cfg_addr register index, cfg_wdata value
//
// Issue makes one palette RAM access per cycle (single port) unless held by
// the block buffer: a palette write is one access, a decode one to four steps,
// one read each (direct color: one step, no read). Texels leave one per cycle
// while out_tready is high; a decode's final read waits until the block buffer
// is known free on arrival. Output stalls hold the output register and block
// buffer; issue keeps running until a decode's final read would find the block
// buffer still busy. Reset is synchronous, active low, and clears control only;
// the palette RAM powers up undefined.
module paletted_texel_decoder #(
  parameter int PALETTE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // entry_address[11:0], data_word[27:12],
                                  // slot_info[43:28], zero pad [47:44]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ptd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  fmt_t                fmt_r;
  logic                t0_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [ENTRIES_W-1:0] entries_r;

  step_t               step;
  logic                fin_ok;
  logic                mem_en, mem_we;
  logic [AW-1:0]       mem_addr;
  logic [COLOR_W-1:0]  mem_wdata, mem_rdata;

  // config registers, written only while the block is idle: a rule for the user that the block leaves unenforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_A3I5;
      t0_r      <= 1'b0;
      offset_r  <= '0;
      entries_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FORMAT:  fmt_r     <= fmt_t'(cfg_wdata[2:0]);
        CFG_T0:      t0_r      <= cfg_wdata[0];
        CFG_OFFSET:  offset_r  <= cfg_wdata;
        CFG_ENTRIES: entries_r <= cfg_wdata[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: one RAM access per cycle unless held for the block buffer, address and range check
  ptd_issue #(.DEPTH(PALETTE_DEPTH)) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_addr   (in_tdata[11:0]),
    .in_word   (in_tdata[27:12]),
    .in_slot   (in_tdata[43:28]),
    .fmt       (fmt_r),
    .t0        (t0_r),
    .offset    (offset_r),
    .entries   (entries_r),
    .fin_ok    (fin_ok),
    .step      (step),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  ptd_palette_ram #(.DEPTH(PALETTE_DEPTH)) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // slot collection, block buffer, texel build and output register
  ptd_texel_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rd_data   (mem_rdata),
    .fin_ok    (fin_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// File: test/paletted_texel_decoder_tb.sv
module paletted_texel_decoder_tb;
  import ptd_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int N_PHASES     = 12;
  localparam int PHASE_ITEMS  = 18;
  localparam int DRAIN_CYCLES = 16;    // issue + texel stage + slack
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STUCK_LIMIT  = 3000;  // cycles without any transaction

  // format code the block gives no meaning to
  localparam logic [2:0] FMT_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } texel_t;

  // Mirrors palette contents and registers; holds the texels still owed.
  class texel_scoreboard;
    logic [14:0] palette [DEPTH];
    logic [2:0]  fmt;
    logic        t0;
    logic [15:0] offset;
    logic [12:0] entries;
    texel_t      owed [$];
    int          errors;

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_FORMAT:  fmt = val[2:0];
        CFG_T0:      t0 = val[0];
        CFG_OFFSET:  offset = val;
        CFG_ENTRIES: entries = val[12:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void owe(texel_t t);
      owed = {owed, t};
    endfunction

    function logic [7:0] widen5(logic [4:0] v);
      return {v, v[4:2]};
    endfunction

    function texel_t from_color(logic [14:0] col, logic [7:0] alpha);
      texel_t t;
      t = '0;
      t.r = widen5(col[4:0]);
      t.g = widen5(col[9:5]);
      t.b = widen5(col[14:10]);
      t.a = alpha;
      return t;
    endfunction

    function bit present(int addr);
      return addr < int'(entries) && addr < DEPTH;
    endfunction

    // palette formats: a missing entry is all zero
    function texel_t pal_texel(int idx, bit use_t0);
      int addr;
      addr = int'(offset) * 4 + idx;
      if (!present(addr)) return '0;
      return from_color(palette[addr], (use_t0 && idx == 0) ? 8'h00 : 8'hFF);
    endfunction

    // compressed blocks: a missing entry is opaque black
    function texel_t opaque_texel(int addr);
      if (!present(addr)) return from_color(15'h0000, 8'hFF);
      return from_color(palette[addr], 8'hFF);
    endfunction

    function texel_t blend(texel_t x, texel_t y, int wx, int wy, int dv);
      texel_t t;
      t = '0;
      t.r = 8'((wx * int'(x.r) + wy * int'(y.r)) / dv);
      t.g = 8'((wx * int'(x.g) + wy * int'(y.g)) / dv);
      t.b = 8'((wx * int'(x.b) + wy * int'(y.b)) / dv);
      t.a = 8'hFF;
      return t;
    endfunction

    function void note_input(op_t op, logic [11:0] addr, logic [15:0] word,
                             logic [15:0] slot);
      texel_t     t;
      texel_t     sub [4];
      logic [7:0] tx;
      logic [2:0] a3;
      logic [4:0] a5;
      int         base;
      if (op == OP_WRITE) begin
        palette[addr] = word[14:0];
        return;
      end
      tx = word[7:0];
      case (fmt)
        FMT_A3I5: begin
          t = pal_texel(int'(tx[4:0]), 1'b0);
          a3 = tx[7:5];
          t.a = {a3, a3, a3[2:1]};
          t.last = 1'b1;
          owe(t);
        end
        FMT_PAL4: begin
          for (int i = 0; i < 4; i++) begin
            t = pal_texel(int'((tx >> (2 * i)) & 8'h03), t0);
            t.last = (i == 3);
            owe(t);
          end
        end
        FMT_PAL16: begin
          for (int i = 0; i < 2; i++) begin
            t = pal_texel(int'((tx >> (4 * i)) & 8'h0F), t0);
            t.last = (i == 1);
            owe(t);
          end
        end
        FMT_PAL256: begin
          t = pal_texel(int'(tx), t0);
          t.last = 1'b1;
          owe(t);
        end
        FMT_COMP: begin
          base = int'(offset) * 4 + int'(slot[13:0]) * 4;
          for (int k = 0; k < 4; k++) sub[k] = '0;  // transparent
          sub[0] = opaque_texel(base);
          sub[1] = opaque_texel(base + 1);
          case (cmp_mode_t'(slot[15:14]))
            CMP_READ3: sub[2] = opaque_texel(base + 2);
            CMP_AVG:   sub[2] = blend(sub[0], sub[1], 1, 1, 2);
            CMP_READ4: begin
              sub[2] = opaque_texel(base + 2);
              sub[3] = opaque_texel(base + 3);
            end
            CMP_BLEND: begin
              sub[2] = blend(sub[0], sub[1], 5, 3, 8);
              sub[3] = blend(sub[0], sub[1], 3, 5, 8);
            end
            default: ;
          endcase
          for (int i = 0; i < 4; i++) begin
            t = sub[(tx >> (2 * i)) & 8'h03];
            t.last = (i == 3);
            owe(t);
          end
        end
        FMT_A5I3: begin
          t = pal_texel(int'(tx[2:0]), 1'b0);
          a5 = tx[7:3];
          t.a = {a5, a5[4:2]};
          t.last = 1'b1;
          owe(t);
        end
        FMT_DIRECT: begin
          t = from_color(word[14:0], word[15] ? 8'hFF : 8'h00);
          t.last = 1'b1;
          owe(t);
        end
        default: ;  // no texels for the unused format
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_texel(logic [31:0] d, logic l);
      texel_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t unexpected texel: expected none, actual %h last %b", $time, d, l);
        return;
      end
      e = owed.pop_front();
      cmp_field("red", e.r, d[7:0]);
      cmp_field("green", e.g, d[15:8]);
      cmp_field("blue", e.b, d[23:16]);
      cmp_field("alpha", e.a, d[31:24]);
      cmp_field("last", 8'(e.last), 8'(l));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // entry_address[11:0], data_word[27:12], slot_info[43:28]
  logic        in_tuser = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  texel_scoreboard sb = new;
  bit written [DEPTH];   // entries loaded so far, as seen by the stimulus
  int snd_idle;
  int rcv_idle;
  bit stall_req;
  int n_items;
  int n_writes;
  int n_texels;
  int n_cfgs;

  paletted_texel_decoder #(.PALETTE_DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        hold = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_texel(out_tdata, out_tlast);
      n_texels++;
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("%0t watchdog: no transaction for %0d cycles, %0d texels outstanding",
             $time, STUCK_LIMIT, sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next call decides whether it drops.
  task automatic send_item(op_t op, logic [11:0] addr, logic [15:0] word,
                           logic [15:0] slot);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, slot, word, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, addr, word, slot);
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_write(logic [11:0] addr, logic [15:0] word);
    written[addr] = 1'b1;
    n_writes++;
    send_item(OP_WRITE, addr, word, 16'($urandom));
  endtask

  // Loads any never-written in-range entry the decode could read (all four of a
  // compressed slot), then sends the decode.
  task automatic send_decode(logic [15:0] word, logic [15:0] slot);
    int reads [$];
    int base;
    base = int'(sb.offset) * 4;
    case (sb.fmt)
      FMT_A3I5:   reads = {reads, base + int'(word[4:0])};
      FMT_A5I3:   reads = {reads, base + int'(word[2:0])};
      FMT_PAL256: reads = {reads, base + int'(word[7:0])};
      FMT_PAL16: begin
        reads = {reads, base + int'(word[3:0])};
        reads = {reads, base + int'(word[7:4])};
      end
      FMT_PAL4: begin
        for (int i = 0; i < 4; i++) reads = {reads, base + int'((word >> (2 * i)) & 3)};
      end
      FMT_COMP: begin
        for (int k = 0; k < 4; k++) reads = {reads, base + int'(slot[13:0]) * 4 + k};
      end
      default: ;
    endcase
    foreach (reads[j]) begin
      if (reads[j] < int'(sb.entries) && reads[j] < DEPTH && !written[reads[j]])
        send_write(12'(reads[j]), 16'($urandom));
    end
    send_item(OP_DECODE, 12'($urandom), word, slot);
  endtask

  // drop tvalid, let every owed texel arrive, then give in-flight writes time
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(logic [2:0] f, logic t, logic [15:0] off, int ent);
    logic [15:0] vals [4];
    vals = '{16'(f), 16'(t), off, 16'(ent)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    n_cfgs++;
  endtask

  task automatic random_phase(bit pressure);
    logic [2:0]  f;
    logic [15:0] off;
    int          ent;
    logic [15:0] slot;
    f = ($urandom_range(39) == 0) ? FMT_UNUSED : 3'($urandom_range(6));
    if (pressure) f = FMT_PAL4;   // four texels per item fills the block fastest
    case ($urandom_range(7))
      0:       off = 16'd0;
      1, 2, 3: off = 16'($urandom_range(8));
      4, 5:    off = 16'($urandom_range(1023));
      6:       off = 16'($urandom_range(1023, 1000));  // base near the top of the store
      default: off = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       ent = 0;
      1:       ent = DEPTH;
      default: ent = int'(off) * 4 + $urandom_range(300);
    endcase
    if (ent > DEPTH) ent = DEPTH;
    apply_config(f, 1'($urandom_range(1)), off, ent);
    if (pressure) stall_req = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(3) == 0) begin
        send_write(12'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(3) == 0) slot = 16'($urandom);
        else slot = {2'($urandom_range(3)), 14'($urandom_range(15))};
        send_decode(16'($urandom), slot);
      end
    end
    wait_idle();
  endtask

  initial begin
    snd_idle = 33;
    rcv_idle = 63;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nothing loaded: rgb reads as zero, alpha still from the texel
    apply_config(FMT_A3I5, 1'b0, 16'd0, 0);
    send_decode(16'h00FF, 16'h0000);
    wait_idle();

    apply_config(FMT_A3I5, 1'b0, 16'd0, 32);
    send_write(12'd0, 16'h0000);
    send_write(12'd1, 16'h7FFF);
    send_write(12'd31, 16'hFFFF);    // top bit dropped
    send_write(12'hFFF, 16'h8000);   // last entry of the store
    send_decode(16'h0000, 16'hFFFF);
    send_decode(16'h00FF, 16'h0000);
    send_decode(16'hFF21, 16'h0000); // upper byte ignored
    wait_idle();

    // index zero transparent, indices 2 and 3 beyond the loaded count
    apply_config(FMT_PAL4, 1'b1, 16'd0, 2);
    send_decode(16'h00E4, 16'h0000);
    wait_idle();

    apply_config(FMT_PAL16, 1'b1, 16'd0, 16);
    send_decode(16'h00F0, 16'h0000);
    wait_idle();

    // largest offset puts every read out of range
    apply_config(FMT_PAL256, 1'b0, 16'hFFFF, DEPTH);
    send_decode(16'h00FF, 16'h0000);
    wait_idle();

    apply_config(FMT_COMP, 1'b0, 16'd0, 8);
    send_decode(16'h00E4, {CMP_READ3, 14'd0});
    send_decode(16'h00E4, {CMP_AVG, 14'd0});
    send_decode(16'h00E4, {CMP_READ4, 14'd0});
    send_decode(16'h00E4, {CMP_BLEND, 14'd1});
    send_decode(16'h001B, 16'hFFFF);  // slot out of range: opaque black
    wait_idle();

    apply_config(FMT_A5I3, 1'b1, 16'd0, 8);
    send_decode(16'h00FF, 16'h0000);
    send_decode(16'h0007, 16'h0000);
    wait_idle();

    apply_config(FMT_DIRECT, 1'b1, 16'd0, 0);
    send_decode(16'h0000, 16'h0000);
    send_decode(16'hFFFF, 16'h0000);
    send_decode(16'h8000, 16'h0000);
    send_decode(16'h7C1F, 16'h0000);
    wait_idle();

    apply_config(FMT_UNUSED, 1'b1, 16'hFFFF, DEPTH);
    send_decode(16'hFFFF, 16'hFFFF);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == N_PHASES / 3) begin
        snd_idle = 63;
        rcv_idle = 33;
      end else if (ph == 2 * N_PHASES / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      random_phase(ph == 2 * N_PHASES / 3);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input transactions (%0d palette writes) and %0d texels",
             n_items, n_writes, n_texels);
    $display("across %0d register settings, with %0d mismatches", n_cfgs, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: paletted_texel_decoder.f
src/ptd_pkg.sv
src/ptd_palette_ram.sv
src/ptd_issue.sv
src/ptd_texel_out.sv
src/paletted_texel_decoder.sv
test/paletted_texel_decoder_tb.sv
